>>> design/ptrd_pkg.sv
// Shared constants, command codes and control/status types for the task release dispatcher.
package ptrd_pkg;

    localparam int TASK_SLOTS = 8;
    localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    localparam int CMD_W = 3;
    localparam int SLOT_W = 4;
    localparam int PERIOD_W = 16;
    localparam int PEND_W = 8;
    localparam int TICK_W = 32;

    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 40;

    localparam logic [PEND_W-1:0] PENDING_MAX = 8'd255;

    localparam logic [CMD_W-1:0] CMD_TICK = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DISPATCH = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADD = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_ENABLE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET_PERIOD = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REQUEST_RUN = 3'd5;

    typedef struct packed {
        logic capture;
        logic tick_step;
        logic disp_step;
        logic single;
        logic result_load;
    } ptrd_ctrl_t;

    typedef struct packed {
        logic idx_last;
        logic hit;
        logic out_busy;
    } ptrd_stat_t;

endpackage

>>> design/periodic_task_release_dispatcher_core.sv
// Top level of the periodic task release dispatcher.
// The block keeps a table of task slots, where the slot index is the priority and slot 0
// is the highest. Commands arrive on the s_axis-style input channel (s_tvalid, s_tready,
// s_tdata); one result per command leaves on the output channel (m_tvalid, m_tready,
// m_tdata). A transaction completes when tvalid and tready are both high at a clock edge.
// A command is taken only while the controller is idle. A tick visits every slot's
// countdown, one slot per cycle, before its result is loaded. A dispatch scans slots in
// priority order, one per cycle, and stops at the first ready slot or at the last slot.
// Add, set enable, set period and request run pass through a single-step state before the
// result state; unused codes go straight to the result state. The next command can be
// accepted in the cycle after the result is loaded. The result sits in an output register;
// the next command is accepted while it waits. If the receiver stalls and a second result
// is finished, the controller holds it and accepts nothing further until the output
// register frees up. Reset clears every slot, the tick counter and the output valid flag.
module periodic_task_release_dispatcher_core
    import ptrd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // Fields from bit 0: cmd[2:0], slot[6:3], period_in[22:7], enable_in[23].
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // Fields from bit 0: ok[0], chosen_slot[4:1], tick_count[36:5], zero fill[39:37].
    output logic [OUT_DATA_W-1:0] m_tdata
);

    ptrd_ctrl_t ctrl;
    ptrd_stat_t stat;

    ptrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_cmd   (s_tdata[CMD_W-1:0]),
        .stat     (stat),
        .in_ready (s_tready),
        .ctrl     (ctrl)
    );

    ptrd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .in_data   (s_tdata),
        .out_ready (m_tready),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

endmodule

>>> design/ptrd_ctrl.sv
// Controller state machine that sequences command handling over the slot table.
module ptrd_ctrl
    import ptrd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [CMD_W-1:0] in_cmd,
    input  ptrd_stat_t       stat,
    output logic             in_ready,
    output ptrd_ctrl_t       ctrl
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_SCAN,
        ST_SINGLE,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.capture = 1'b1;
                    case (in_cmd)
                        CMD_TICK:     state_next = ST_TICK;
                        CMD_DISPATCH: state_next = ST_SCAN;
                        CMD_ADD, CMD_SET_ENABLE, CMD_SET_PERIOD, CMD_REQUEST_RUN:
                            state_next = ST_SINGLE;
                        default:      state_next = ST_RESULT;
                    endcase
                end
            end
            ST_TICK:
            begin
                ctrl.tick_step = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_SCAN:
            begin
                ctrl.disp_step = 1'b1;
                if (stat.hit || stat.idx_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_SINGLE:
            begin
                ctrl.single = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!stat.out_busy)
                begin
                    ctrl.result_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/ptrd_datapath.sv
// Datapath with the slot table, tick counter, working result and output register.
module ptrd_datapath
    import ptrd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ptrd_ctrl_t            ctrl,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic                  out_ready,
    output ptrd_stat_t            stat,
    output logic                  out_valid,
    output logic [OUT_DATA_W-1:0] out_data
);

    logic [CMD_W-1:0]    cmd_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic                enable_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [TICK_W-1:0]   tick_reg;
    logic                ok_reg;
    logic [SLOT_W-1:0]   chosen_reg;
    logic                out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic                valid_reg [TASK_SLOTS];
    logic                en_reg [TASK_SLOTS];
    logic [PERIOD_W-1:0] period_tbl_reg [TASK_SLOTS];
    logic [PERIOD_W-1:0] cd_reg [TASK_SLOTS];
    logic [PEND_W-1:0]   pend_reg [TASK_SLOTS];

    logic [CMD_W-1:0]    in_cmd;
    logic [IDX_W-1:0]    sidx;
    logic [IDX_W-1:0]    addr;
    logic                in_range;
    logic                rd_valid;
    logic                rd_en;
    logic [PERIOD_W-1:0] rd_period;
    logic [PERIOD_W-1:0] rd_cd;
    logic [PEND_W-1:0]   rd_pend;
    logic [PERIOD_W-1:0] cd_dec;
    logic [PEND_W-1:0]   pend_inc;
    logic                live;
    logic                hit;

    assign in_cmd = in_data[CMD_W-1:0];
    assign sidx = slot_reg[IDX_W-1:0];
    assign in_range = {1'b0, slot_reg} < (SLOT_W+1)'(TASK_SLOTS);
    assign addr = ctrl.single ? sidx : idx_reg;

    assign rd_valid = valid_reg[addr];
    assign rd_en = en_reg[addr];
    assign rd_period = period_tbl_reg[addr];
    assign rd_cd = cd_reg[addr];
    assign rd_pend = pend_reg[addr];

    assign cd_dec = rd_cd - PERIOD_W'(1);
    assign pend_inc = (rd_pend == PENDING_MAX) ? rd_pend : rd_pend + PEND_W'(1);
    assign live = in_range && rd_valid;
    assign hit = rd_valid && rd_en && (rd_pend != '0);

    assign stat.idx_last = (idx_reg == IDX_W'(TASK_SLOTS - 1));
    assign stat.hit = hit;
    assign stat.out_busy = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg <= in_cmd;
            slot_reg <= in_data[CMD_W +: SLOT_W];
            period_reg <= in_data[CMD_W+SLOT_W +: PERIOD_W];
            enable_reg <= in_data[CMD_W+SLOT_W+PERIOD_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            tick_reg <= '0;
            ok_reg <= 1'b0;
            chosen_reg <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg <= '0;
            for (int i = 0; i < TASK_SLOTS; i++)
            begin
                valid_reg[i] <= 1'b0;
                en_reg[i] <= 1'b0;
                period_tbl_reg[i] <= '0;
                cd_reg[i] <= '0;
                pend_reg[i] <= '0;
            end
        end
        else
        begin
            if (ctrl.capture)
            begin
                idx_reg <= '0;
                ok_reg <= (in_cmd == CMD_TICK);
                chosen_reg <= '0;
                if (in_cmd == CMD_TICK)
                begin
                    tick_reg <= tick_reg + TICK_W'(1);
                end
            end

            if (ctrl.tick_step)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
                if (rd_valid && rd_en && (rd_cd != '0))
                begin
                    if (cd_dec == '0)
                    begin
                        pend_reg[addr] <= pend_inc;
                        cd_reg[addr] <= rd_period;
                    end
                    else
                    begin
                        cd_reg[addr] <= cd_dec;
                    end
                end
            end

            if (ctrl.disp_step)
            begin
                if (hit)
                begin
                    pend_reg[addr] <= rd_pend - PEND_W'(1);
                    ok_reg <= 1'b1;
                    chosen_reg <= SLOT_W'(idx_reg);
                end
                else
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end

            if (ctrl.single)
            begin
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (in_range)
                        begin
                            valid_reg[addr] <= 1'b1;
                            en_reg[addr] <= 1'b1;
                            period_tbl_reg[addr] <= period_reg;
                            cd_reg[addr] <= period_reg;
                            pend_reg[addr] <= PEND_W'(1);
                            ok_reg <= 1'b1;
                        end
                    end
                    CMD_SET_ENABLE:
                    begin
                        if (live)
                        begin
                            en_reg[addr] <= enable_reg;
                            ok_reg <= 1'b1;
                        end
                    end
                    CMD_SET_PERIOD:
                    begin
                        if (live)
                        begin
                            period_tbl_reg[addr] <= period_reg;
                            ok_reg <= 1'b1;
                        end
                    end
                    CMD_REQUEST_RUN:
                    begin
                        if (live)
                        begin
                            pend_reg[addr] <= pend_inc;
                            ok_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                        ok_reg <= 1'b0;
                    end
                endcase
            end

            if (ctrl.result_load)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg <= {3'b000, tick_reg, chosen_reg, ok_reg};
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> test/tb_periodic_task_release_dispatcher_core.sv
// Self-checking testbench for periodic_task_release_dispatcher_core using a scheduler model.
`timescale 1ns / 1ps

module tb_periodic_task_release_dispatcher_core;
    import ptrd_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = TASK_SLOTS + 8;
    localparam int RANDOM_PER_PHASE = 270;
    localparam int SATURATE_RUNS = 258;
    localparam int SATURATE_SLOT = TASK_SLOTS - 3;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [SLOT_W-1:0]   slot;
        logic [PERIOD_W-1:0] period;
        logic                enable;
    } sched_cmd_t;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] chosen;
        logic [TICK_W-1:0] ticks;
    } sched_result_t;

    typedef struct packed {
        sched_cmd_t    c;
        logic          typed;
        sched_result_t want;
    } directed_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    bit              tbl_valid     [TASK_SLOTS];
    bit              tbl_enabled   [TASK_SLOTS];
    bit [PERIOD_W-1:0] tbl_period  [TASK_SLOTS];
    bit [PERIOD_W-1:0] tbl_countdown [TASK_SLOTS];
    bit [PEND_W-1:0] tbl_pending   [TASK_SLOTS];
    bit [TICK_W-1:0] ticks_seen;

    sched_result_t awaited_results [$];
    int            mismatches = 0;
    int            idle_cycles = 0;
    int            sender_idle_pct;
    int            sink_stall_pct;

    directed_row_t directed_rows [0:24] = '{
        '{'{CMD_TICK,        4'd0,  16'd0,     1'b0}, 1'b1, '{1'b1, 4'd0, 32'd1}},
        '{'{CMD_DISPATCH,    4'd0,  16'd0,     1'b0}, 1'b1, '{1'b0, 4'd0, 32'd1}},
        '{'{CMD_SET_ENABLE,  4'd3,  16'd0,     1'b1}, 1'b1, '{1'b0, 4'd0, 32'd1}},
        '{'{CMD_SET_PERIOD,  4'd3,  16'hFFFF,  1'b0}, 1'b1, '{1'b0, 4'd0, 32'd1}},
        '{'{CMD_REQUEST_RUN, 4'd3,  16'd0,     1'b0}, 1'b1, '{1'b0, 4'd0, 32'd1}},
        '{'{CMD_UNUSED_6,    4'd0,  16'd0,     1'b0}, 1'b1, '{1'b0, 4'd0, 32'd1}},
        '{'{CMD_UNUSED_7,    4'd15, 16'hFFFF,  1'b1}, 1'b1, '{1'b0, 4'd0, 32'd1}},
        '{'{CMD_ADD,         4'd15, 16'hFFFF,  1'b1}, 1'b1, '{1'b0, 4'd0, 32'd1}},
        '{'{CMD_ADD,         4'd8,  16'd1,     1'b0}, 1'b1, '{1'b0, 4'd0, 32'd1}},
        '{'{CMD_ADD,         4'd0,  16'd0,     1'b0}, 1'b1, '{1'b1, 4'd0, 32'd1}},
        '{'{CMD_ADD,         4'd7,  16'hFFFF,  1'b0}, 1'b1, '{1'b1, 4'd0, 32'd1}},
        '{'{CMD_ADD,         4'd3,  16'd2,     1'b1}, 1'b1, '{1'b1, 4'd0, 32'd1}},
        '{'{CMD_DISPATCH,    4'd0,  16'd0,     1'b0}, 1'b1, '{1'b1, 4'd0, 32'd1}},
        '{'{CMD_DISPATCH,    4'd0,  16'd0,     1'b0}, 1'b1, '{1'b1, 4'd3, 32'd1}},
        '{'{CMD_DISPATCH,    4'd0,  16'd0,     1'b0}, 1'b1, '{1'b1, 4'd7, 32'd1}},
        '{'{CMD_DISPATCH,    4'd0,  16'd0,     1'b0}, 1'b1, '{1'b0, 4'd0, 32'd1}},
        '{'{CMD_TICK,        4'd0,  16'd0,     1'b0}, 1'b0, '0},
        '{'{CMD_TICK,        4'd0,  16'd0,     1'b0}, 1'b0, '0},
        '{'{CMD_SET_PERIOD,  4'd3,  16'd1,     1'b0}, 1'b0, '0},
        '{'{CMD_SET_ENABLE,  4'd7,  16'd0,     1'b0}, 1'b0, '0},
        '{'{CMD_REQUEST_RUN, 4'd7,  16'd0,     1'b0}, 1'b0, '0},
        '{'{CMD_DISPATCH,    4'd0,  16'd0,     1'b0}, 1'b0, '0},
        '{'{CMD_DISPATCH,    4'd0,  16'd0,     1'b0}, 1'b0, '0},
        '{'{CMD_SET_ENABLE,  4'd7,  16'h5555,  1'b1}, 1'b0, '0},
        '{'{CMD_DISPATCH,    4'd0,  16'hAAAA,  1'b0}, 1'b0, '0}
    };

    periodic_task_release_dispatcher_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic sched_result_t schedule_step(input sched_cmd_t c);
        sched_result_t r;
        bit            live;
        bit            found;
        int            s;
        r = '0;
        s = c.slot;
        live = (s < TASK_SLOTS) && tbl_valid[s];
        case (c.cmd)
            CMD_TICK:
            begin
                ticks_seen = ticks_seen + 1'b1;
                for (int k = 0; k < TASK_SLOTS; k++)
                begin
                    if (tbl_valid[k] && tbl_enabled[k] && tbl_countdown[k] != '0)
                    begin
                        tbl_countdown[k] = tbl_countdown[k] - 1'b1;
                        if (tbl_countdown[k] == '0)
                        begin
                            if (tbl_pending[k] != PENDING_MAX)
                                tbl_pending[k] = tbl_pending[k] + 1'b1;
                            tbl_countdown[k] = tbl_period[k];
                        end
                    end
                end
                r.ok = 1'b1;
            end
            CMD_DISPATCH:
            begin
                found = 1'b0;
                for (int k = 0; k < TASK_SLOTS; k++)
                begin
                    if (!found && tbl_valid[k] && tbl_enabled[k] && tbl_pending[k] != '0)
                    begin
                        found = 1'b1;
                        tbl_pending[k] = tbl_pending[k] - 1'b1;
                        r.chosen = SLOT_W'(k);
                        r.ok = 1'b1;
                    end
                end
            end
            CMD_ADD:
            begin
                if (s < TASK_SLOTS)
                begin
                    tbl_valid[s] = 1'b1;
                    tbl_enabled[s] = 1'b1;
                    tbl_period[s] = c.period;
                    tbl_countdown[s] = c.period;
                    tbl_pending[s] = PEND_W'(1);
                    r.ok = 1'b1;
                end
            end
            CMD_SET_ENABLE:
            begin
                if (live)
                begin
                    tbl_enabled[s] = c.enable;
                    r.ok = 1'b1;
                end
            end
            CMD_SET_PERIOD:
            begin
                if (live)
                begin
                    tbl_period[s] = c.period;
                    r.ok = 1'b1;
                end
            end
            CMD_REQUEST_RUN:
            begin
                if (live)
                begin
                    if (tbl_pending[s] != PENDING_MAX)
                        tbl_pending[s] = tbl_pending[s] + 1'b1;
                    r.ok = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.ticks = ticks_seen;
        return r;
    endfunction

    function automatic sched_cmd_t random_cmd();
        sched_cmd_t c;
        int         pick;
        int         span;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            c.cmd = CMD_TICK;
        else if (pick < 55)
            c.cmd = CMD_DISPATCH;
        else if (pick < 67)
            c.cmd = CMD_ADD;
        else if (pick < 77)
            c.cmd = CMD_SET_ENABLE;
        else if (pick < 85)
            c.cmd = CMD_SET_PERIOD;
        else if (pick < 95)
            c.cmd = CMD_REQUEST_RUN;
        else if (pick < 98)
            c.cmd = CMD_UNUSED_6;
        else
            c.cmd = CMD_UNUSED_7;
        if ($urandom_range(0, 99) < 85)
            c.slot = SLOT_W'($urandom_range(0, TASK_SLOTS - 1));
        else
            c.slot = SLOT_W'($urandom_range(0, 15));
        span = $urandom_range(0, 99);
        if (span < 50)
            c.period = PERIOD_W'($urandom_range(1, 6));
        else if (span < 65)
            c.period = '0;
        else
            c.period = PERIOD_W'($urandom);
        c.enable = ($urandom_range(0, 99) < 75);
        return c;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic send_cmd(input sched_cmd_t c, input logic typed, input sched_result_t want);
        sched_result_t got;
        while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {c.enable, c.period, c.slot, c.cmd};
        do
            @(posedge clk);
        while (!s_tready);
        got = schedule_step(c);
        awaited_results.push_back(typed ? want : got);
        @(negedge clk);
    endtask

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= !(sink_stall_pct > 0 && $urandom_range(0, 99) < sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        sched_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_results.size() == 0)
                report_mismatch($sformatf("unexpected result 0x%h", m_tdata));
            else
            begin
                want = awaited_results.pop_front();
                if (m_tdata[0] !== want.ok)
                    report_mismatch($sformatf("ok %b, expected %b", m_tdata[0], want.ok));
                if (m_tdata[4:1] !== want.chosen)
                    report_mismatch($sformatf("chosen_slot %0d, expected %0d",
                                              m_tdata[4:1], want.chosen));
                if (m_tdata[36:5] !== want.ticks)
                    report_mismatch($sformatf("tick_count %0d, expected %0d",
                                              m_tdata[36:5], want.ticks));
                if (m_tdata[39:37] !== 3'b000)
                    report_mismatch($sformatf("fill bits %b, expected 000", m_tdata[39:37]));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        sched_cmd_t c;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        sender_idle_pct = 0;
        sink_stall_pct = 0;
        ticks_seen = '0;
        for (int k = 0; k < TASK_SLOTS; k++)
        begin
            tbl_valid[k] = 1'b0;
            tbl_enabled[k] = 1'b0;
            tbl_period[k] = '0;
            tbl_countdown[k] = '0;
            tbl_pending[k] = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 72 : 11) : 0;
            sink_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 72 : 11) : 0;
            if (phase == 0)
            begin
                foreach (directed_rows[i])
                    send_cmd(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].want);
                // Drive one slot's run count into saturation with back-to-back run requests.
                c = '{CMD_ADD, SLOT_W'(SATURATE_SLOT), 16'd0, 1'b1};
                send_cmd(c, 1'b0, '0);
                c.cmd = CMD_REQUEST_RUN;
                repeat (SATURATE_RUNS) send_cmd(c, 1'b0, '0);
            end
            repeat (RANDOM_PER_PHASE) send_cmd(random_cmd(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
